// File: hw/rtl/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

  // protocol class codes as reported on the result channel
  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_FAST  = 2'd1,
    CLS_SLOW  = 2'd2,
    CLS_SERVO = 2'd3
  } class_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FAST_MIN    = 3'd0,
    REG_FAST_AVG    = 3'd1,
    REG_SLOW_MIN    = 3'd2,
    REG_SLOW_AVG    = 3'd3,
    REG_SERVO_FLOOR = 3'd4
  } reg_idx_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_e;

  // classifier thresholds
  typedef struct packed {
    logic [7:0]  fast_min;
    logic [15:0] fast_avg;
    logic [7:0]  slow_min;
    logic [15:0] slow_avg;
    logic [14:0] servo_floor;
  } limits_t;

  // one result beat
  typedef struct packed {
    class_e      protocol_class;
    logic        input_set;
    logic [14:0] smallest_width;
    logic [15:0] average_width;
    logic [6:0]  capture_prescaler;
    logic [1:0]  telemetry_prescaler;
    logic [5:0]  transfer_length;
    logic [13:0] arm_threshold;
  } result_t;

  localparam logic [14:0] MIN_START = 15'd20000;

  // threshold reset values
  localparam logic [7:0]  FAST_MIN_RST    = 8'd4;
  localparam logic [15:0] FAST_AVG_RST    = 16'd60;
  localparam logic [7:0]  SLOW_MIN_RST    = 8'd8;
  localparam logic [15:0] SLOW_AVG_RST    = 16'd100;
  localparam logic [14:0] SERVO_FLOOR_RST = 15'd30;

  // timer settings per protocol
  localparam logic [6:0]  CAP_PSC_RST   = 7'd16;
  localparam logic [6:0]  CAP_PSC_FAST  = 7'd0;
  localparam logic [6:0]  CAP_PSC_SLOW  = 7'd1;
  localparam logic [6:0]  CAP_PSC_SERVO = 7'd119;
  localparam logic [1:0]  TLM_PSC_RST   = 2'd0;
  localparam logic [1:0]  TLM_PSC_FAST  = 2'd1;
  localparam logic [1:0]  TLM_PSC_SLOW  = 2'd3;
  localparam logic [5:0]  XFER_DSHOT    = 6'd32;
  localparam logic [5:0]  XFER_SERVO    = 6'd2;
  localparam logic [5:0]  XFER_RST      = 6'd32;
  localparam logic [13:0] ARM_DSHOT     = 14'd10000;
  localparam logic [13:0] ARM_SERVO     = 14'd35;
  localparam logic [13:0] ARM_RST       = 14'd0;

  // divide by ten: (x * 52429) >> 19, exact for 15-bit x
  localparam logic [15:0] TENTH_MUL = 16'd52429;
  localparam int          TENTH_SHIFT = 19;

  // front to back queue
  localparam int Q_DEPTH = 2;

endpackage

`default_nettype wire

// File: hw/rtl/ipc_front.sv
`default_nettype none

module ipc_front #(
  parameter int PAIR_COUNT = 16,
  localparam int SUM_W = 16 + $clog2(PAIR_COUNT + 1),
  localparam int CNT_W = $clog2(PAIR_COUNT + 1),
  localparam int DW = 15 + SUM_W + CNT_W
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [15:0]   capture_value_i,
  output logic               push_o,
  input  wire logic          push_ready_i,
  output logic [DW-1:0]      push_data_o
);

  localparam int IDX_W = $clog2(2 * PAIR_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(2 * PAIR_COUNT - 1);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [15:0]      first_q, first_d;
  logic [14:0]      min_q, min_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic        accept;
  logic        last;
  logic        counted;
  logic [15:0] width;
  logic [14:0] min_new;
  logic [SUM_W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;

  assign last       = (idx_q == LAST_IDX);
  assign in_stall_o = last && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  // pair width and running statistics including this beat
  assign width   = capture_value_i - first_q;
  assign counted = idx_q[0] && (capture_value_i > first_q);
  assign min_new = (counted && (width < {1'b0, min_q})) ? width[14:0] : min_q;
  assign sum_new = counted ? sum_q + SUM_W'(width) : sum_q;
  assign cnt_new = counted ? cnt_q + CNT_W'(1) : cnt_q;

  // hand the frame summary to the queue on the last stamp
  assign push_o      = accept && last;
  assign push_data_o = {min_new, sum_new, cnt_new};

  always_comb begin
    idx_d   = idx_q;
    first_d = first_q;
    min_d   = min_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    if (accept) begin
      if (!idx_q[0]) begin
        first_d = capture_value_i;
      end
      if (last) begin
        idx_d   = '0;
        first_d = '0;
        min_d   = ipc_pkg::MIN_START;
        sum_d   = '0;
        cnt_d   = '0;
      end else begin
        idx_d = idx_q + IDX_W'(1);
        min_d = min_new;
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      first_q <= '0;
      min_q   <= ipc_pkg::MIN_START;
      sum_q   <= '0;
      cnt_q   <= '0;
    end else begin
      idx_q   <= idx_d;
      first_q <= first_d;
      min_q   <= min_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ipc_queue.sv
`default_nettype none

module ipc_queue #(
  parameter int DW = 37
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  output logic               push_ready_o,
  input  wire logic [DW-1:0] push_data_i,
  output logic               pop_valid_o,
  input  wire logic          pop_i,
  output logic [DW-1:0]      pop_data_o
);

  localparam int PTR_W = $clog2(ipc_pkg::Q_DEPTH);
  localparam int FILL_W = $clog2(ipc_pkg::Q_DEPTH + 1);

  logic [DW-1:0]     mem_q [ipc_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FILL_W-1:0] fill_q;
  logic              do_push, do_pop;

  assign push_ready_o = (fill_q != FILL_W'(ipc_pkg::Q_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FILL_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FILL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ipc_back.sv
`default_nettype none

module ipc_back #(
  parameter int PAIR_COUNT = 16,
  localparam int SUM_W = 16 + $clog2(PAIR_COUNT + 1),
  localparam int CNT_W = $clog2(PAIR_COUNT + 1),
  localparam int DW = 15 + SUM_W + CNT_W
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pop_valid_i,
  output logic                 pop_o,
  input  wire logic [DW-1:0]   pop_data_i,
  input  wire ipc_pkg::limits_t limits_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output ipc_pkg::result_t     result_o
);

  localparam int STEP_W = $clog2(SUM_W);

  ipc_pkg::bk_state_e state_q, state_d;

  logic [14:0]       min_q, min_d;
  logic [11:0]       tenth_q, tenth_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic [6:0]  cap_psc_q, cap_psc_d;
  logic [1:0]  tlm_psc_q, tlm_psc_d;
  logic [5:0]  xfer_q, xfer_d;
  logic [13:0] arm_q, arm_d;

  logic             out_valid_q, out_valid_d;
  ipc_pkg::result_t res_q, res_d;

  logic [14:0]      ld_min;
  logic [SUM_W-1:0] ld_sum;
  logic [CNT_W-1:0] ld_cnt;
  logic [30:0]      tenth_prod;
  logic [CNT_W:0]   rem_shift;
  logic [CNT_W:0]   rem_sub;
  logic             rem_ge;
  logic [15:0]      avg;
  logic             fast_hit, slow_hit, servo_hit;
  logic             out_free;

  assign {ld_min, ld_sum, ld_cnt} = pop_data_i;
  assign tenth_prod = 31'(ld_min) * 31'(ipc_pkg::TENTH_MUL);

  // one restoring divide step: quotient bits shift into the dividend register
  assign rem_shift = {rem_q, dvd_q[SUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, dvs_q};
  assign rem_ge    = (rem_shift >= {1'b0, dvs_q});

  // classify on the finished quotient
  assign avg      = dvd_q[15:0];
  assign fast_hit = (min_q > 15'd1) && (min_q <= 15'(limits_i.fast_min))
                    && (avg < limits_i.fast_avg);
  assign slow_hit = (min_q > 15'(limits_i.fast_min)) && (min_q <= 15'(limits_i.slow_min))
                    && (avg < limits_i.slow_avg);
  assign servo_hit = (min_q > limits_i.servo_floor) && (min_q < ipc_pkg::MIN_START)
                     && ({1'b0, avg} < (17'(min_q) + 17'(tenth_q)));

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  always_comb begin
    state_d     = state_q;
    min_d       = min_q;
    tenth_d     = tenth_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    step_d      = step_q;
    cap_psc_d   = cap_psc_q;
    tlm_psc_d   = tlm_psc_q;
    xfer_d      = xfer_q;
    arm_d       = arm_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    pop_o       = 1'b0;

    unique case (state_q)
      ipc_pkg::BK_IDLE: begin
        // take a frame summary and start the divide
        if (pop_valid_i) begin
          pop_o   = 1'b1;
          min_d   = ld_min;
          tenth_d = tenth_prod[ipc_pkg::TENTH_SHIFT +: 12];
          dvd_d   = ld_sum;
          dvs_d   = (ld_cnt == '0) ? CNT_W'(1) : ld_cnt;
          rem_d   = '0;
          step_d  = STEP_W'(SUM_W - 1);
          state_d = ipc_pkg::BK_DIV;
        end
      end
      ipc_pkg::BK_DIV: begin
        rem_d  = rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        dvd_d  = {dvd_q[SUM_W-2:0], rem_ge};
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = ipc_pkg::BK_DONE;
        end
      end
      ipc_pkg::BK_DONE: begin
        // servo settings are applied last so they win over dshot
        if (out_free) begin
          if (fast_hit) begin
            cap_psc_d = ipc_pkg::CAP_PSC_FAST;
            tlm_psc_d = ipc_pkg::TLM_PSC_FAST;
            xfer_d    = ipc_pkg::XFER_DSHOT;
            arm_d     = ipc_pkg::ARM_DSHOT;
          end
          if (slow_hit) begin
            cap_psc_d = ipc_pkg::CAP_PSC_SLOW;
            tlm_psc_d = ipc_pkg::TLM_PSC_SLOW;
            xfer_d    = ipc_pkg::XFER_DSHOT;
            arm_d     = ipc_pkg::ARM_DSHOT;
          end
          if (servo_hit) begin
            cap_psc_d = ipc_pkg::CAP_PSC_SERVO;
            xfer_d    = ipc_pkg::XFER_SERVO;
            arm_d     = ipc_pkg::ARM_SERVO;
          end
          if (servo_hit) begin
            res_d.protocol_class = ipc_pkg::CLS_SERVO;
          end else if (slow_hit) begin
            res_d.protocol_class = ipc_pkg::CLS_SLOW;
          end else if (fast_hit) begin
            res_d.protocol_class = ipc_pkg::CLS_FAST;
          end else begin
            res_d.protocol_class = ipc_pkg::CLS_NONE;
          end
          res_d.input_set           = fast_hit || slow_hit || servo_hit;
          res_d.smallest_width      = min_q;
          res_d.average_width       = avg;
          res_d.capture_prescaler   = cap_psc_d;
          res_d.telemetry_prescaler = tlm_psc_d;
          res_d.transfer_length     = xfer_d;
          res_d.arm_threshold       = arm_d;
          out_valid_d               = 1'b1;
          state_d                   = ipc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = ipc_pkg::BK_IDLE;
      end
    endcase
  end

  // sequencer, held settings and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipc_pkg::BK_IDLE;
      cap_psc_q   <= ipc_pkg::CAP_PSC_RST;
      tlm_psc_q   <= ipc_pkg::TLM_PSC_RST;
      xfer_q      <= ipc_pkg::XFER_RST;
      arm_q       <= ipc_pkg::ARM_RST;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      cap_psc_q   <= cap_psc_d;
      tlm_psc_q   <= tlm_psc_d;
      xfer_q      <= xfer_d;
      arm_q       <= arm_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    min_q   <= min_d;
    tenth_q <= tenth_d;
    dvd_q   <= dvd_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    res_q   <= res_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/input_protocol_classifier_top.sv
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+--------------------------------
// input    | in        | in_valid_i / in_stall_o   | capture_value_i
// result   | out       | out_valid_o / out_stall_i | class, widths, timer settings
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one stamp is taken per cycle unless the input is stalled; a frame is 2*PAIR_COUNT stamps
// the back end runs a bit-serial restoring divide over the SUM_W-bit frame sum
// (SUM_W = 16 + clog2(PAIR_COUNT+1), 21 at 16 pairs), overlapped with the next frame
// input stalls only on the last stamp of a frame while the two-entry queue is full
// reset returns the frame statistics, thresholds and held timer settings to their reset values at once
`default_nettype none

module input_protocol_classifier_top #(
  parameter int PAIR_COUNT = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] capture_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       protocol_class_o,
  output logic             input_set_o,
  output logic [14:0]      smallest_width_o,
  output logic [15:0]      average_width_o,
  output logic [6:0]       capture_prescaler_o,
  output logic [1:0]       telemetry_prescaler_o,
  output logic [5:0]       transfer_length_o,
  output logic [13:0]      arm_threshold_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int SUM_W = 16 + $clog2(PAIR_COUNT + 1);
  localparam int CNT_W = $clog2(PAIR_COUNT + 1);
  localparam int DW = 15 + SUM_W + CNT_W;

  ipc_pkg::limits_t limits_q;
  ipc_pkg::result_t result;

  logic          push, push_ready;
  logic [DW-1:0] push_data;
  logic          pop_valid, pop;
  logic [DW-1:0] pop_data;

  // threshold registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.fast_min    <= ipc_pkg::FAST_MIN_RST;
      limits_q.fast_avg    <= ipc_pkg::FAST_AVG_RST;
      limits_q.slow_min    <= ipc_pkg::SLOW_MIN_RST;
      limits_q.slow_avg    <= ipc_pkg::SLOW_AVG_RST;
      limits_q.servo_floor <= ipc_pkg::SERVO_FLOOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ipc_pkg::REG_FAST_MIN:    limits_q.fast_min    <= cfg_data_i[7:0];
        ipc_pkg::REG_FAST_AVG:    limits_q.fast_avg    <= cfg_data_i;
        ipc_pkg::REG_SLOW_MIN:    limits_q.slow_min    <= cfg_data_i[7:0];
        ipc_pkg::REG_SLOW_AVG:    limits_q.slow_avg    <= cfg_data_i;
        ipc_pkg::REG_SERVO_FLOOR: limits_q.servo_floor <= cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  ipc_front #(
    .PAIR_COUNT(PAIR_COUNT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .capture_value_i(capture_value_i),
    .push_o         (push),
    .push_ready_i   (push_ready),
    .push_data_o    (push_data)
  );

  ipc_queue #(
    .DW(DW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  ipc_back #(
    .PAIR_COUNT(PAIR_COUNT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .limits_i   (limits_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result)
  );

  assign protocol_class_o      = result.protocol_class;
  assign input_set_o           = result.input_set;
  assign smallest_width_o      = result.smallest_width;
  assign average_width_o       = result.average_width;
  assign capture_prescaler_o   = result.capture_prescaler;
  assign telemetry_prescaler_o = result.telemetry_prescaler;
  assign transfer_length_o     = result.transfer_length;
  assign arm_threshold_o       = result.arm_threshold;

`ifndef SYNTHESIS
  // a frame summary is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> push_ready)
    else $error("frame summary pushed into full queue");

  // input_set follows the reported class
  a_set_matches_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (input_set_o == (protocol_class_o != ipc_pkg::CLS_NONE)))
    else $error("input_set disagrees with protocol class");

  // a fast dshot result carries the fast timer settings
  a_fast_settings: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (protocol_class_o == ipc_pkg::CLS_FAST)) |->
      ((capture_prescaler_o == ipc_pkg::CAP_PSC_FAST)
       && (telemetry_prescaler_o == ipc_pkg::TLM_PSC_FAST)
       && (arm_threshold_o == ipc_pkg::ARM_DSHOT)))
    else $error("fast dshot result with wrong timer settings");

  // a servo result needs a real pulse width
  a_servo_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (protocol_class_o == ipc_pkg::CLS_SERVO)) |->
      (smallest_width_o < ipc_pkg::MIN_START))
    else $error("servo class without a valid pulse");
`endif

endmodule

`default_nettype wire
